// File: src/stxy_pkg.sv
// Package for the spiral index to position block: field widths, register
// indexes, reset values and pipeline sizing helpers.
// No dependencies.
package stxy_pkg;

   localparam int INDEX_BITS_DEF = 32;
   localparam int FIELD_BITS     = 32;
   localparam int POS_BITS       = 17;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [CSR_DATA_BITS-1:0] SCREEN_WIDTH_RESET  = 16'd640;
   localparam logic [CSR_DATA_BITS-1:0] SCREEN_HEIGHT_RESET = 16'd480;

   typedef logic [FIELD_BITS-1:0]      index_type;
   typedef logic signed [POS_BITS-1:0] pos_type;

   // index bits actually used
   function automatic int used_bits(input int index_bits);
      return (index_bits < FIELD_BITS) ? index_bits : FIELD_BITS;
   endfunction

   // one root bit per square root stage
   function automatic int sqrt_steps(input int index_bits);
      return (used_bits(index_bits) + 1) / 2;
   endfunction

   // input stage, root stages, edge stage, output stage
   function automatic int pipe_depth(input int index_bits);
      return sqrt_steps(index_bits) + 3;
   endfunction

endpackage

// File: src/stxy_if.sv
// Handshake interfaces for the index beat and the position beat.
// Depends on stxy_pkg.
interface stxy_req_if;
   logic                 valid;
   logic                 ready;
   stxy_pkg::index_type  spiral_index;

   modport source (output valid, output spiral_index, input ready);
   modport sink   (input valid, input spiral_index, output ready);
endinterface

interface stxy_rsp_if;
   logic               valid;
   logic               ready;
   stxy_pkg::pos_type  x_pos;
   stxy_pkg::pos_type  y_pos;

   modport source (output valid, output x_pos, output y_pos, input ready);
   modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

// File: src/spiral_index_to_xy.sv
// Stages: input, one per root bit, edge, output. One index beat per cycle unless the
// output stalls; a full stage holds its beat while the next stage cannot load.
// Reset (synchronous, active high) empties the pipeline and sets the screen to 640 x 480.
// Depends on stxy_pkg and stxy_if.
module spiral_index_to_xy #(
   parameter int INDEX_BITS = stxy_pkg::INDEX_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   stxy_req_if.sink                             req_chan,
   stxy_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_en,
   input  logic [stxy_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [stxy_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int NB   = stxy_pkg::used_bits(INDEX_BITS);
   localparam int K    = stxy_pkg::sqrt_steps(INDEX_BITS);
   localparam int MB   = 2 * K;
   localparam int RW   = K + 1;
   localparam int DW   = K + 4;
   localparam int PB   = stxy_pkg::POS_BITS;
   localparam int SW   = ((DW > PB) ? DW : PB) + 1;
   localparam int EDGE = K + 1;
   localparam int LAST = K + 2;

   localparam logic signed [DW-1:0] ONE_S = DW'(1);

   logic [stxy_pkg::CSR_DATA_BITS-1:0] screen_width_ff;
   logic [stxy_pkg::CSR_DATA_BITS-1:0] screen_height_ff;

   logic [LAST:0]   v_ff;
   logic [LAST:0]   adv;
   logic [MB-1:0]   m_ff     [0:K-1];
   logic [RW-1:0]   rem_ff   [0:K];
   logic [K-1:0]    root_ff  [0:K];
   logic            small_ff [0:K];

   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [PB-1:0] x_pos_ff, y_pos_ff;
   logic signed [SW-1:0] x_sum, y_sum;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= stxy_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= stxy_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            stxy_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            stxy_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
         endcase
      end
   end

   // a stage loads when it is empty or its beat moves on
   assign adv[LAST] = !v_ff[LAST] || rsp_chan.ready;
   for (genvar j = 0; j < LAST; j++) begin : g_adv
      assign adv[j] = !v_ff[j] || adv[j+1];
   end

   assign req_chan.ready = adv[0];

   // input stage
   logic [NB-1:0] n_idx;
   assign n_idx = req_chan.spiral_index[NB-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         v_ff[0] <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         m_ff[0]     <= MB'(n_idx - NB'(1));
         small_ff[0] <= (n_idx < NB'(2));
         rem_ff[0]   <= '0;
         root_ff[0]  <= '0;
      end
   end

   // square root of index - 1, one root bit per stage
   for (genvar j = 1; j <= K; j++) begin : g_sqrt
      logic [RW+1:0] cat;
      logic [RW+1:0] diff;
      logic [RW:0]   trial;
      logic          fits;

      always_comb begin
         cat   = {rem_ff[j-1], m_ff[j-1][MB-1 -: 2]};
         trial = {root_ff[j-1], 2'b01};
         diff  = cat - {1'b0, trial};
         fits  = (cat >= {1'b0, trial});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (adv[j]) begin
            v_ff[j] <= v_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[j]) begin
            rem_ff[j]   <= fits ? diff[RW-1:0] : cat[RW-1:0];
            root_ff[j]  <= {root_ff[j-1][K-2:0], fits};
            small_ff[j] <= small_ff[j-1];
         end
      end

      if (j < K) begin : g_shift
         always_ff @(posedge clock) begin
            if (adv[j]) begin
               m_ff[j] <= {m_ff[j-1][MB-3:0], 2'b00};
            end
         end
      end
   end

   // edge select: odd root gives right or top edge, even root left or bottom
   logic [K-1:0]         r_val;
   logic signed [DW-1:0] rs, ss, ts;
   logic                 first_edge;

   always_comb begin
      r_val      = K'(({1'b0, root_ff[K]} + (K+1)'(root_ff[K][0])) >> 1);
      rs         = signed'(DW'(r_val));
      ss         = signed'(DW'(root_ff[K]));
      ts         = signed'(DW'(rem_ff[K]));
      first_edge = (RW'(root_ff[K]) >= rem_ff[K]);
      if (small_ff[K]) begin
         dx_in = '0;
         dy_in = '0;
      end else if (root_ff[K][0]) begin
         if (first_edge) begin
            dx_in = rs;
            dy_in = rs - ts - ONE_S;
         end else begin
            dx_in = rs + ss - ts;
            dy_in = -rs;
         end
      end else begin
         if (first_edge) begin
            dx_in = -rs;
            dy_in = ts - rs;
         end else begin
            dx_in = ts - ss - rs;
            dy_in = rs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[EDGE] <= 1'b0;
      end else if (adv[EDGE]) begin
         v_ff[EDGE] <= v_ff[K];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[EDGE]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   // add the screen center
   assign x_sum = SW'(signed'({1'b0, screen_width_ff[stxy_pkg::CSR_DATA_BITS-1:1]}))
                + SW'(dx_ff);
   assign y_sum = SW'(signed'({1'b0, screen_height_ff[stxy_pkg::CSR_DATA_BITS-1:1]}))
                + SW'(dy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[LAST] <= 1'b0;
      end else if (adv[LAST]) begin
         v_ff[LAST] <= v_ff[EDGE];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[LAST]) begin
         x_pos_ff <= x_sum[PB-1:0];
         y_pos_ff <= y_sum[PB-1:0];
      end
   end

   assign rsp_chan.valid = v_ff[LAST];
   assign rsp_chan.x_pos = x_pos_ff;
   assign rsp_chan.y_pos = y_pos_ff;

endmodule

// File: src/stxy_checker.sv
// Port-level checks for spiral_index_to_xy and the bind that attaches them.
// Depends on stxy_pkg.
module stxy_checker #(
   parameter int INDEX_BITS = stxy_pkg::INDEX_BITS_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input stxy_pkg::pos_type  x_pos,
   input stxy_pkg::pos_type  y_pos
);

   localparam int DEPTH = stxy_pkg::pipe_depth(INDEX_BITS);
   localparam int CW    = $clog2(DEPTH + 2);

   logic [CW-1:0] count_ff, count_in;

   // count beats in flight
   always_comb begin
      count_in = count_ff;
      if (req_valid && req_ready) count_in = count_in + CW'(1);
      if (rsp_valid && rsp_ready) count_in = count_in - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(x_pos) && $stable(y_pos))
      else $error("stalled position beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("position beat after reset");

   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("index beat refused while output drains");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> count_ff != '0)
      else $error("position beat without index beat");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("more beats in flight than stages");

endmodule

bind spiral_index_to_xy stxy_checker #(.INDEX_BITS(INDEX_BITS)) u_stxy_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .x_pos     (rsp_chan.x_pos),
   .y_pos     (rsp_chan.y_pos)
);

// File: sim/tb_spiral_index_to_xy.sv
// Self-checking bench for spiral_index_to_xy: a behavioral predictor checks every
// position beat while both handshakes idle at random. Several screen sizes are used.
// Depends on stxy_pkg, stxy_if and the spiral_index_to_xy RTL.
module tb_spiral_index_to_xy;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int DRAIN_CYCLES     = stxy_pkg::pipe_depth(stxy_pkg::INDEX_BITS_DEF) + 4;
   localparam int RANDOM_PHASES    = 5;
   localparam int RANDOM_PER_PHASE = 90;

   typedef struct packed {
      stxy_pkg::pos_type x_pos;
      stxy_pkg::pos_type y_pos;
   } position_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_en;
   logic [stxy_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [stxy_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   stxy_req_if req_bus ();
   stxy_rsp_if rsp_bus ();

   position_type                       pending_positions [$];
   logic [stxy_pkg::CSR_DATA_BITS-1:0] screen_w;
   logic [stxy_pkg::CSR_DATA_BITS-1:0] screen_h;
   int                                 idle_pct;
   int                                 error_count = 0;
   int                                 cycle_count = 0;

   spiral_index_to_xy i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_bus),
      .rsp_chan     (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned res;
      longint unsigned trial;
      res = 0;
      for (int b = 16; b >= 0; b--) begin
         trial = res | (64'd1 << b);
         if (trial * trial <= v)
            res = trial;
      end
      return res;
   endfunction

   function automatic position_type spiral_position(
         input stxy_pkg::index_type                idx,
         input logic [stxy_pkg::CSR_DATA_BITS-1:0] w,
         input logic [stxy_pkg::CSR_DATA_BITS-1:0] h);
      longint unsigned n;
      longint unsigned r;
      longint unsigned sq4;
      longint unsigned c_start;
      longint unsigned c_tr;
      longint unsigned c_tl;
      longint unsigned c_bl;
      longint          rs;
      longint          dx;
      longint          dy;
      longint          xs;
      longint          ys;
      position_type    p;
      n  = idx;
      dx = 0;
      dy = 0;
      if (n >= 2) begin
         r       = (floor_root(n - 1) + 1) >> 1;
         rs      = longint'(r);
         sq4     = 4 * r * r;
         c_start = sq4 - 4 * r + 2;
         c_tr    = sq4 - 2 * r + 1;
         c_tl    = sq4 + 1;
         c_bl    = sq4 + 2 * r + 1;
         if (n <= c_tr) begin
            dx = rs;
            dy = rs - 1 - longint'(n - c_start);
         end else if (n <= c_tl) begin
            dy = -rs;
            dx = rs - longint'(n - c_tr);
         end else if (n <= c_bl) begin
            dx = -rs;
            dy = -rs + longint'(n - c_tl);
         end else begin
            dy = rs;
            dx = -rs + longint'(n - c_bl);
         end
      end
      xs = longint'(w >> 1) + dx;
      ys = longint'(h >> 1) + dy;
      p.x_pos = xs[stxy_pkg::POS_BITS-1:0];
      p.y_pos = ys[stxy_pkg::POS_BITS-1:0];
      return p;
   endfunction

   // mostly small indices and ring corners, the rest across the full field
   function automatic stxy_pkg::index_type random_index();
      longint unsigned r;
      longint unsigned sq4;
      longint unsigned n;
      int              pick;
      pick = $urandom_range(99);
      if (pick < 40)
         return stxy_pkg::index_type'($urandom_range(2000));
      if (pick < 65)
         return stxy_pkg::index_type'($urandom);
      if (pick < 80)
         return stxy_pkg::index_type'($urandom) | 32'hC000_0000;
      r   = $urandom_range(32767, 1);
      sq4 = 4 * r * r;
      case ($urandom_range(3))
         0:       n = sq4 - 4 * r + 2;
         1:       n = sq4 - 2 * r + 1;
         2:       n = sq4 + 1;
         default: n = sq4 + 2 * r + 1;
      endcase
      n = n + $urandom_range(2) - 1;
      return n[stxy_pkg::FIELD_BITS-1:0];
   endfunction

   task automatic send_index(input stxy_pkg::index_type idx);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid        <= 1'b0;
         req_bus.spiral_index <= stxy_pkg::index_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.valid        <= 1'b1;
      req_bus.spiral_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      pending_positions.push_back(spiral_position(idx, screen_w, screen_h));
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_positions.size() != 0);
   endtask

   task automatic set_screen(input logic [stxy_pkg::CSR_DATA_BITS-1:0] w,
                             input logic [stxy_pkg::CSR_DATA_BITS-1:0] h);
      wait_idle();
      csr_write_en <= 1'b1;
      csr_index    <= stxy_pkg::CSR_SCREEN_WIDTH;
      csr_wdata    <= w;
      @(posedge clock);
      csr_index    <= stxy_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata    <= h;
      @(posedge clock);
      csr_write_en <= 1'b0;
      screen_w = w;
      screen_h = h;
   endtask

   task automatic test_default_screen();
      for (int i = 0; i <= 10; i++)
         send_index(stxy_pkg::index_type'(i));
      wait_idle();
   endtask

   task automatic test_outer_ring();
      stxy_pkg::index_type ring_edges [6];
      ring_edges = '{32'hFFFE_0001, 32'hFFFE_0002, 32'hFFFF_0001,
                     32'hFFFF_0002, 32'hFFFF_FFFF, 32'h8000_0000};
      foreach (ring_edges[i])
         send_index(ring_edges[i]);
      wait_idle();
   endtask

   task automatic test_screen_extremes();
      set_screen(16'h0000, 16'h0000);
      send_index(32'hFFFF_FFFF);
      send_index(32'hFFFF_0001);
      send_index(32'd1);
      set_screen(16'hFFFF, 16'hFFFF);
      send_index(32'hFFFF_0001);
      send_index(32'hFFFE_0001);
      set_screen(16'h0001, 16'h0001);
      send_index(32'd2);
      wait_idle();
   endtask

   task automatic test_random_indices();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       set_screen(stxy_pkg::SCREEN_WIDTH_RESET, stxy_pkg::SCREEN_HEIGHT_RESET);
            2:       set_screen(16'hFFFF, 16'h0000);
            3:       set_screen(16'h0000, 16'hFFFF);
            default: set_screen(16'($urandom), 16'($urandom));
         endcase
         idle_pct = (phase == 2) ? 0 : 25;
         repeat (RANDOM_PER_PHASE)
            send_index(random_index());
      end
      wait_idle();
      idle_pct = 25;
   endtask

   always @(posedge clock) begin : position_check
      position_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_positions.size() == 0) begin
            $display("%0t: position beat with none pending: expected none, actual x %0d y %0d",
                     $time, $signed(rsp_bus.x_pos), $signed(rsp_bus.y_pos));
            error_count++;
         end else begin
            want = pending_positions.pop_front();
            if (rsp_bus.x_pos !== want.x_pos) begin
               $display("%0t: x_pos mismatch: expected %0d, actual %0d",
                        $time, $signed(want.x_pos), $signed(rsp_bus.x_pos));
               error_count++;
            end
            if (rsp_bus.y_pos !== want.y_pos) begin
               $display("%0t: y_pos mismatch: expected %0d, actual %0d",
                        $time, $signed(want.y_pos), $signed(rsp_bus.y_pos));
               error_count++;
            end
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("spiral_index_to_xy regression: fail");
         $finish;
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_write_en         = 1'b0;
      csr_index            = stxy_pkg::CSR_SCREEN_WIDTH;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.spiral_index = '0;
      rsp_bus.ready        = 1'b0;
      screen_w             = stxy_pkg::SCREEN_WIDTH_RESET;
      screen_h             = stxy_pkg::SCREEN_HEIGHT_RESET;
      idle_pct             = 25;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_default_screen();
      test_outer_ring();
      test_screen_extremes();
      test_random_indices();
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_positions.size() == 0) begin
         $display("spiral_index_to_xy regression: pass");
      end else begin
         $display("spiral_index_to_xy regression: fail");
      end
      $finish;
   end

endmodule
